// File: rtl/mcpat_pkg.sv
// ----------------------------------------------------------------------------
// mcpat_pkg
// shared types and constants of the multi-channel periodic alarm timer
// ----------------------------------------------------------------------------
`default_nettype none

package mcpat_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int COUNT_WIDTH  = 16;
    localparam int CHAN_WIDTH   = 3;
    localparam int FIELD_WIDTH  = 16;
    localparam int PRESC_WIDTH  = 3;
    localparam int DIV_WIDTH    = 2;

    localparam int S_TDATA_WIDTH = 56;
    localparam int S_TUSER_WIDTH = 2;
    localparam int M_TDATA_WIDTH = 32;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CFG_DAT_WIDTH = 2;

    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef logic [NUM_CHANNELS-1:0] chan_mask_t;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_NOW  = 2'd1,
        CMD_SET_REF  = 2'd2,
        CMD_UNSET    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_RUN_ENABLE   = 2'd0,
        REG_CLOCK_DIV    = 2'd1,
        REG_OVF_IRQ_EN   = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_CHAN = 1'b1;

endpackage

`default_nettype wire

// File: rtl/multi_channel_periodic_alarm_timer.sv
// ----------------------------------------------------------------------------
// multi_channel_periodic_alarm_timer
// 16-bit counter with prescaler and seven compare-match alarm channels
// the result is written to the output register at the accepting edge
// throughput: one transaction per cycle unless m_tready stalls the output; the counter
// and channel state update at the accepting edge, so the next item sees it immediately
// reset: aresetn synchronous active low, clears counter, prescaler, channels
// and configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_periodic_alarm_timer
    import mcpat_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DAT_WIDTH-1:0] cfg_wdata,

    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // channel[2:0], delay_ticks[18:3], reload_period[34:19], reference_time[50:35]
    input  wire logic [S_TDATA_WIDTH-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [S_TUSER_WIDTH-1:0] s_tuser,

    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // fired_mask[6:0], overflow_event[7], count_now[23:8], status[24]
    output logic [M_TDATA_WIDTH-1:0]      m_tdata
);

    logic                 run_enable_reg;
    logic [DIV_WIDTH-1:0] clock_div_reg;
    logic                 ovf_irq_en_reg;

    count_t                 counter_reg, counter_next;
    logic [PRESC_WIDTH-1:0] presc_reg, presc_next;
    count_t                 compare_reg [NUM_CHANNELS];
    count_t                 compare_next [NUM_CHANNELS];
    count_t                 period_reg [NUM_CHANNELS];
    count_t                 period_next [NUM_CHANNELS];
    chan_mask_t             enable_reg, enable_next;

    logic                     m_tvalid_reg;
    logic [M_TDATA_WIDTH-1:0] m_tdata_reg, m_tdata_next;

    cmd_t                   cmd_in;
    logic [CHAN_WIDTH-1:0]  chan_in;
    logic [FIELD_WIDTH-1:0] delay_in;
    logic [FIELD_WIDTH-1:0] period_in;
    logic [FIELD_WIDTH-1:0] ref_in;

    logic                   accept;
    logic [PRESC_WIDTH-1:0] limit;
    logic                   step;
    logic                   bad_chan;
    count_t                 count_inc;
    count_t                 set_value;
    chan_mask_t             fired;
    logic                   ovf;

    assign cmd_in    = cmd_t'(s_tuser);
    assign chan_in   = s_tdata[2:0];
    assign delay_in  = s_tdata[18:3];
    assign period_in = s_tdata[34:19];
    assign ref_in    = s_tdata[50:35];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        limit     = PRESC_WIDTH'((4'd1 << clock_div_reg) - 4'd1);
        step      = (cmd_in == CMD_TICK) && run_enable_reg && (presc_reg >= limit);
        bad_chan  = (cmd_in != CMD_TICK) && (chan_in >= CHAN_WIDTH'(NUM_CHANNELS));
        count_inc = counter_reg + count_t'(1);
        set_value = ((cmd_in == CMD_SET_NOW) ? counter_reg : count_t'(ref_in))
                    + count_t'(delay_in);

        counter_next = counter_reg;
        presc_next   = presc_reg;
        enable_next  = enable_reg;
        fired        = '0;
        ovf          = 1'b0;

        if (cmd_in == CMD_TICK && run_enable_reg) begin
            if (step) begin
                presc_next   = '0;
                counter_next = count_inc;
                ovf          = (count_inc == '0) && ovf_irq_en_reg;
            end else begin
                presc_next = presc_reg + PRESC_WIDTH'(1);
            end
        end

        for (int c = 0; c < NUM_CHANNELS; c++) begin
            compare_next[c] = compare_reg[c];
            period_next[c]  = period_reg[c];
            if (step && enable_reg[c] && compare_reg[c] == count_inc) begin
                fired[c] = 1'b1;
                if (period_reg[c] != '0) begin
                    compare_next[c] = compare_reg[c] + period_reg[c];
                end else begin
                    compare_next[c] = '0;
                    enable_next[c]  = 1'b0;
                end
            end
            if (cmd_in != CMD_TICK && !bad_chan && chan_in == CHAN_WIDTH'(c)) begin
                if (cmd_in == CMD_UNSET) begin
                    compare_next[c] = '0;
                    period_next[c]  = '0;
                    enable_next[c]  = 1'b0;
                end else begin
                    compare_next[c] = set_value;
                    period_next[c]  = count_t'(period_in);
                    enable_next[c]  = 1'b1;
                end
            end
        end

        m_tdata_next        = '0;
        m_tdata_next[6:0]   = fired;
        m_tdata_next[7]     = ovf;
        m_tdata_next[23:8]  = counter_next;
        m_tdata_next[24]    = bad_chan ? STATUS_BAD_CHAN : STATUS_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_enable_reg <= 1'b0;
            clock_div_reg  <= '0;
            ovf_irq_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_RUN_ENABLE: run_enable_reg <= cfg_wdata[0];
                REG_CLOCK_DIV:  clock_div_reg  <= cfg_wdata[DIV_WIDTH-1:0];
                REG_OVF_IRQ_EN: ovf_irq_en_reg <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg  <= '0;
            presc_reg    <= '0;
            enable_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                compare_reg[c] <= '0;
                period_reg[c]  <= '0;
            end
        end else begin
            if (accept) begin
                counter_reg <= counter_next;
                presc_reg   <= presc_next;
                enable_reg  <= enable_next;
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    compare_reg[c] <= compare_next[c];
                    period_reg[c]  <= period_next[c];
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

// File: dv/multi_channel_periodic_alarm_timer_checker.sv
// ----------------------------------------------------------------------------
// multi_channel_periodic_alarm_timer_checker
// watches the config port and both streams, predicts each result from its own
// copy of the counter, prescaler and channel state, and compares in order
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_periodic_alarm_timer_checker
    import mcpat_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DAT_WIDTH-1:0] cfg_wdata,
    input  wire logic                     s_tvalid,
    input  wire logic                     s_tready,
    // channel[2:0], delay_ticks[18:3], reload_period[34:19], reference_time[50:35]
    input  wire logic [S_TDATA_WIDTH-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [S_TUSER_WIDTH-1:0] s_tuser,
    input  wire logic                     m_tvalid,
    input  wire logic                     m_tready,
    // fired_mask[6:0], overflow_event[7], count_now[23:8], status[24]
    input  wire logic [M_TDATA_WIDTH-1:0] m_tdata,
    output int                            fail_count,
    output int                            outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        chan_mask_t fired;
        logic       overflow;
        count_t     count;
        logic       status;
    } timer_result_t;

    timer_result_t timer_results[$];

    count_t                 counter;
    logic [PRESC_WIDTH-1:0] prescale;
    count_t                 compare [NUM_CHANNELS];
    count_t                 period  [NUM_CHANNELS];
    logic                   armed   [NUM_CHANNELS];
    logic                   run_en;
    logic [DIV_WIDTH-1:0]   divider;
    logic                   ovf_en;

    task automatic timer_step(input cmd_t cmd, input logic [CHAN_WIDTH-1:0] chan,
                              input count_t delay, input count_t reload,
                              input count_t ref_time);
        timer_result_t          r;
        logic [PRESC_WIDTH-1:0] limit;
        count_t                 base;
        r = '0;
        r.status = STATUS_OK;
        if (cmd == CMD_TICK) begin
            if (run_en) begin
                limit = PRESC_WIDTH'((1 << divider) - 1);
                if (prescale >= limit) begin
                    prescale = '0;
                    counter = counter + 1'b1;
                    if (counter == '0 && ovf_en)
                        r.overflow = 1'b1;
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (armed[c] && compare[c] == counter) begin
                            r.fired[c] = 1'b1;
                            if (period[c] != '0) begin
                                compare[c] = compare[c] + period[c];
                            end else begin
                                compare[c] = '0;
                                armed[c] = 1'b0;
                            end
                        end
                    end
                end else begin
                    prescale = prescale + 1'b1;
                end
            end
        end else if (chan >= NUM_CHANNELS) begin
            r.status = STATUS_BAD_CHAN;
        end else if (cmd == CMD_UNSET) begin
            compare[chan] = '0;
            period[chan] = '0;
            armed[chan] = 1'b0;
        end else begin
            base = (cmd == CMD_SET_NOW) ? counter : ref_time;
            compare[chan] = base + delay;
            period[chan] = reload;
            armed[chan] = 1'b1;
        end
        r.count = counter;
        timer_results.push_back(r);
    endtask

    always @(posedge aclk) begin
        timer_result_t want;
        timer_result_t got;
        if (!aresetn) begin
            counter = '0;
            prescale = '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                compare[c] = '0;
                period[c] = '0;
                armed[c] = 1'b0;
            end
            run_en = 1'b0;
            divider = '0;
            ovf_en = 1'b0;
            timer_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_RUN_ENABLE: run_en = cfg_wdata[0];
                    REG_CLOCK_DIV:  divider = cfg_wdata[DIV_WIDTH-1:0];
                    REG_OVF_IRQ_EN: ovf_en = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                timer_step(cmd_t'(s_tuser), s_tdata[2:0], s_tdata[18:3],
                           s_tdata[34:19], s_tdata[50:35]);
            if (m_tvalid && m_tready) begin
                got.fired = m_tdata[6:0];
                got.overflow = m_tdata[7];
                got.count = m_tdata[23:8];
                got.status = m_tdata[24];
                if (timer_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result transaction %h", $realtime, m_tdata);
                    fail_count++;
                end else begin
                    want = timer_results.pop_front();
                    if (got.fired !== want.fired || got.overflow !== want.overflow ||
                        got.count !== want.count || got.status !== want.status) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch fired %h/%h ovf %b/%b count %h/%h status %b/%b",
                                     $realtime, want.fired, got.fired, want.overflow,
                                     got.overflow, want.count, got.count, want.status,
                                     got.status);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = timer_results.size();
    end

endmodule

`default_nettype wire

// File: dv/multi_channel_periodic_alarm_timer_test.sv
// ----------------------------------------------------------------------------
// multi_channel_periodic_alarm_timer_test
// directed and random stimulus for the alarm timer: arming, reload, one-shot,
// bad channels, prescaler changes, under varied idling
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_periodic_alarm_timer_test;

    import mcpat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_DAT_WIDTH-1:0] cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata;
    logic [S_TUSER_WIDTH-1:0] s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    int errors;
    int outstanding;
    int idle_pct;
    int stall_pct;
    bit hold_req;

    multi_channel_periodic_alarm_timer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    multi_channel_periodic_alarm_timer_checker timer_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (errors),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (64) @(posedge aclk);
            end
            m_tready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    task automatic send_item(input cmd_t cmd, input logic [CHAN_WIDTH-1:0] chan,
                             input count_t delay, input count_t reload,
                             input count_t ref_time);
        while ($urandom_range(1, 100) <= idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'b0, ref_time, reload, delay, chan};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_config(input logic run, input logic [1:0] div, input logic ovf);
        logic [1:0] vals [4];
        vals[REG_RUN_ENABLE] = {1'b0, run};
        vals[REG_CLOCK_DIV] = div;
        vals[REG_OVF_IRQ_EN] = {1'b0, ovf};
        vals[REG_UNUSED] = 2'($urandom);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_wdata <= vals[i] | (i == REG_RUN_ENABLE || i == REG_OVF_IRQ_EN ?
                                    {1'($urandom_range(0, 1)), 1'b0} : 2'b00);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_item();
        int     pick;
        count_t delay;
        count_t reload;
        count_t ref_time;
        pick = $urandom_range(0, 99);
        delay = ($urandom_range(0, 3) != 0) ? count_t'($urandom_range(0, 15))
                                            : count_t'($urandom);
        pick = pick;
        case ($urandom_range(0, 9))
            0, 1, 2: reload = '0;
            3, 4:    reload = count_t'($urandom);
            default: reload = count_t'($urandom_range(1, 20));
        endcase
        ref_time = ($urandom_range(0, 1) != 0) ? count_t'($urandom_range(0, 300))
                                               : count_t'($urandom);
        if (pick < 60)
            send_item(CMD_TICK, 3'($urandom), count_t'($urandom), count_t'($urandom),
                      count_t'($urandom));
        else if (pick < 75)
            send_item(CMD_SET_NOW, 3'($urandom), delay, reload, ref_time);
        else if (pick < 87)
            send_item(CMD_SET_REF, 3'($urandom), delay, reload, ref_time);
        else
            send_item(CMD_UNSET, 3'($urandom), delay, reload, ref_time);
    endtask

    initial begin
        static int         seg_idle  [5] = '{0, 77, 0, 35, 35};
        static int         seg_stall [5] = '{0, 0, 77, 35, 0};
        static logic       seg_run   [5] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
        static logic [1:0] seg_div   [5] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2};
        static logic       seg_ovf   [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stopped counter, ignored channel field on a tick
        send_item(CMD_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
        write_config(1'b1, 2'd0, 1'b1);
        send_item(CMD_SET_NOW, 3'd0, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(CMD_SET_REF, 3'd1, 16'd2, 16'd0, 16'hFFFF);
        send_item(CMD_SET_NOW, 3'd6, 16'd3, 16'd1, 16'h0000);
        send_item(CMD_SET_REF, 3'd2, 16'd0, 16'd2, 16'h0000);
        send_item(CMD_SET_NOW, 3'd7, 16'd1, 16'd1, 16'd1);
        send_item(CMD_SET_REF, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_UNSET, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_UNSET, 3'd0, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 6; i++)
            send_item(CMD_TICK, 3'($urandom), 16'd0, 16'd0, 16'd0);
        send_item(CMD_UNSET, 3'd6, 16'd0, 16'd0, 16'd0);
        // divider lowered while the prescaler sits above the new limit
        drain();
        write_config(1'b1, 2'd3, 1'b1);
        for (int i = 0; i < 3; i++)
            send_item(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
        drain();
        write_config(1'b1, 2'd1, 1'b1);
        for (int i = 0; i < 3; i++)
            send_item(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
        drain();

        // alarm armed at the current count, overflow reporting on and off
        write_config(1'b1, 2'd0, 1'b1);
        send_item(CMD_SET_NOW, 3'd0, 16'd0, 16'd0, 16'd0);
        send_item(CMD_SET_NOW, 3'd3, 16'hFFFF, 16'd0, 16'd0);
        for (int i = 0; i < 24; i++)
            send_item(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        drain();
        write_config(1'b1, 2'd0, 1'b0);
        for (int i = 0; i < 24; i++)
            send_item(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        drain();

        for (int seg = 0; seg < 5; seg++) begin
            write_config(seg_run[seg], seg_div[seg], seg_ovf[seg]);
            idle_pct = seg_idle[seg];
            stall_pct = seg_stall[seg];
            for (int i = 0; i < 90; i++) begin
                if (seg == 0 && i == 40)
                    hold_req = 1'b1;
                random_item();
            end
            drain();
        end

        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
